>>> hw/rtl/md5_pkg.sv
// Shared types, constants and round functions of the MD5 stream hasher.
`default_nettype none

package md5_pkg;

  localparam int unsigned PC_W  = 4;
  localparam int unsigned CNT_W = 61;

  localparam logic [1:0] CMD_ABSORB  = 2'd0;
  localparam logic [1:0] CMD_FINISH  = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;
  localparam logic [1:0] CMD_READ    = 2'd3;

  localparam logic [31:0] IV_TAB [4] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;
  localparam logic [5:0] LAST_POS = 6'd63;
  localparam logic [5:0] LAST_RND = 6'd63;

  localparam logic [31:0] K_TAB [64] = '{
    32'hD76AA478, 32'hE8C7B756, 32'h242070DB, 32'hC1BDCEEE,
    32'hF57C0FAF, 32'h4787C62A, 32'hA8304613, 32'hFD469501,
    32'h698098D8, 32'h8B44F7AF, 32'hFFFF5BB1, 32'h895CD7BE,
    32'h6B901122, 32'hFD987193, 32'hA679438E, 32'h49B40821,
    32'hF61E2562, 32'hC040B340, 32'h265E5A51, 32'hE9B6C7AA,
    32'hD62F105D, 32'h02441453, 32'hD8A1E681, 32'hE7D3FBC8,
    32'h21E1CDE6, 32'hC33707D6, 32'hF4D50D87, 32'h455A14ED,
    32'hA9E3E905, 32'hFCEFA3F8, 32'h676F02D9, 32'h8D2A4C8A,
    32'hFFFA3942, 32'h8771F681, 32'h6D9D6122, 32'hFDE5380C,
    32'hA4BEEA44, 32'h4BDECFA9, 32'hF6BB4B60, 32'hBEBFBC70,
    32'h289B7EC6, 32'hEAA127FA, 32'hD4EF3085, 32'h04881D05,
    32'hD9D4D039, 32'hE6DB99E5, 32'h1FA27CF8, 32'hC4AC5665,
    32'hF4292244, 32'h432AFF97, 32'hAB9423A7, 32'hFC93A039,
    32'h655B59C3, 32'h8F0CCC92, 32'hFFEFF47D, 32'h85845DD1,
    32'h6FA87E4F, 32'hFE2CE6E0, 32'hA3014314, 32'h4E0811A1,
    32'hF7537E82, 32'hBD3AF235, 32'h2AD7D2BB, 32'hEB86D391
  };

  localparam logic [4:0] ROT_TAB [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  typedef enum logic [1:0] {
    SRC_DATA,
    SRC_PAD,
    SRC_ZERO,
    SRC_LEN
  } src_e;

  typedef enum logic [3:0] {
    COND_NEXT,
    COND_JUMP,
    COND_DISPATCH,
    COND_ABS_CONT,
    COND_LEN_CONT,
    COND_POS56,
    COND_EMIT,
    COND_ROUND,
    COND_RET
  } cond_e;

  typedef struct packed {
    logic            accept;
    logic            abs_en;
    src_e            src;
    logic            len_cap;
    logic            load_iv;
    logic            cmp_init;
    logic            cmp_round;
    logic            cmp_add;
    logic            emit;
    cond_e           cond;
    logic [PC_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic wrap;
    logic pos56;
    logic round_last;
    logic emit_last;
    logic out_free;
  } stat_t;

  function automatic logic [3:0] msg_idx(input logic [5:0] r);
    logic [3:0] r4;
    logic [3:0] g;
    r4 = r[3:0];
    unique case (r[5:4])
      2'd0:    g = r4;
      2'd1:    g = 4'(r4 * 4'd5 + 4'd1);
      2'd2:    g = 4'(r4 * 4'd3 + 4'd5);
      default: g = 4'(r4 * 4'd7);
    endcase
    return g;
  endfunction

  function automatic logic [31:0] round_f(input logic [1:0] phase, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    unique case (phase)
      2'd0:    f = (b & c) | (~b & d);
      2'd1:    f = (d & b) | (~d & c);
      2'd2:    f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    return f;
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] w;
    w = {x, x} << s;
    return w[63:32];
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/md5_stream_hasher_unit.sv
// Top level of the MD5 stream hasher: sequencer plus datapath.
//
// Input channel (in_valid_i/in_ready_o) carries cmd_i and data_byte_i; the
// output channel (out_valid_o/out_ready_i) carries digest_word_o,
// word_index_o and last_word_o. A microcoded sequencer steps a one-round
// datapath; in_ready_o is high only while the program sits at its idle step.
// The absorb byte that completes a 64-byte block also runs the compression
// (one load step, 64 rounds, one chaining add). Read emits its four words
// and returns to idle. Finish absorbs the padding byte by byte (a zero byte
// takes a zero step and a check step, the length bytes one repeated step),
// runs one or two compressions, then emits four words.
// Results leave through a one-deep output register: when the receiver
// stalls, the emit step holds until the register is free again.
// Reset loads the MD5 initial chaining words, clears the byte count and
// returns the program to idle; the block buffer is left as it is.
`default_nettype none

module md5_stream_hasher_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  cmd_i,
  input  wire logic [7:0]  data_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      digest_word_o,
  output logic [1:0]       word_index_o,
  output logic             last_word_o
);

  md5_pkg::ctrl_t ctrl;
  md5_pkg::stat_t stat;
  logic           in_acc;

  assign in_ready_o = ctrl.accept;
  assign in_acc     = in_valid_i && ctrl.accept;

  md5_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cmd_i      (cmd_i),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  md5_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .in_acc_i      (in_acc),
    .data_byte_i   (data_byte_i),
    .out_ready_i   (out_ready_i),
    .stat_o        (stat),
    .out_valid_o   (out_valid_o),
    .digest_word_o (digest_word_o),
    .word_index_o  (word_index_o),
    .last_word_o   (last_word_o)
  );

endmodule

`default_nettype wire

>>> hw/rtl/md5_seq.sv
// Microcode sequencer: program store, step counter, return register and jumps.
`default_nettype none

module md5_seq (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  input  wire logic [1:0]            cmd_i,
  input  wire md5_pkg::stat_t        stat_i,
  output md5_pkg::ctrl_t             ctrl_o
);

  localparam logic [md5_pkg::PC_W-1:0] S_IDLE    = 4'd0;
  localparam logic [md5_pkg::PC_W-1:0] S_ABSORB  = 4'd1;
  localparam logic [md5_pkg::PC_W-1:0] S_RESTART = 4'd2;
  localparam logic [md5_pkg::PC_W-1:0] S_FIN_PAD = 4'd3;
  localparam logic [md5_pkg::PC_W-1:0] S_FIN_CHK = 4'd4;
  localparam logic [md5_pkg::PC_W-1:0] S_FIN_ZER = 4'd5;
  localparam logic [md5_pkg::PC_W-1:0] S_FIN_LEN = 4'd6;
  localparam logic [md5_pkg::PC_W-1:0] S_EMIT    = 4'd7;
  localparam logic [md5_pkg::PC_W-1:0] S_CMP_INI = 4'd8;
  localparam logic [md5_pkg::PC_W-1:0] S_CMP_RND = 4'd9;
  localparam logic [md5_pkg::PC_W-1:0] S_CMP_ADD = 4'd10;

  function automatic md5_pkg::ctrl_t rom(input logic [md5_pkg::PC_W-1:0] pc);
    md5_pkg::ctrl_t w;
    w        = '0;
    w.src    = md5_pkg::SRC_DATA;
    w.cond   = md5_pkg::COND_JUMP;
    w.target = S_IDLE;
    unique case (pc)
      S_IDLE: begin
        w.accept = 1'b1;
        w.cond   = md5_pkg::COND_DISPATCH;
      end
      S_ABSORB: begin
        w.abs_en = 1'b1;
        w.cond   = md5_pkg::COND_ABS_CONT;
      end
      S_RESTART: begin
        w.load_iv = 1'b1;
      end
      S_FIN_PAD: begin
        w.abs_en  = 1'b1;
        w.src     = md5_pkg::SRC_PAD;
        w.len_cap = 1'b1;
        w.cond    = md5_pkg::COND_ABS_CONT;
        w.target  = S_FIN_CHK;
      end
      S_FIN_CHK: begin
        w.cond   = md5_pkg::COND_POS56;
        w.target = S_FIN_LEN;
      end
      S_FIN_ZER: begin
        w.abs_en = 1'b1;
        w.src    = md5_pkg::SRC_ZERO;
        w.cond   = md5_pkg::COND_ABS_CONT;
        w.target = S_FIN_CHK;
      end
      S_FIN_LEN: begin
        w.abs_en = 1'b1;
        w.src    = md5_pkg::SRC_LEN;
        w.cond   = md5_pkg::COND_LEN_CONT;
        w.target = S_EMIT;
      end
      S_EMIT: begin
        w.emit = 1'b1;
        w.cond = md5_pkg::COND_EMIT;
      end
      S_CMP_INI: begin
        w.cmp_init = 1'b1;
        w.cond     = md5_pkg::COND_NEXT;
      end
      S_CMP_RND: begin
        w.cmp_round = 1'b1;
        w.cond      = md5_pkg::COND_ROUND;
      end
      S_CMP_ADD: begin
        w.cmp_add = 1'b1;
        w.cond    = md5_pkg::COND_RET;
      end
      default: begin
      end
    endcase
    return w;
  endfunction

  function automatic logic [md5_pkg::PC_W-1:0] entry(input logic [1:0] cmd);
    logic [md5_pkg::PC_W-1:0] e;
    unique case (cmd)
      md5_pkg::CMD_ABSORB:  e = S_ABSORB;
      md5_pkg::CMD_FINISH:  e = S_FIN_PAD;
      md5_pkg::CMD_RESTART: e = S_RESTART;
      default:              e = S_EMIT;
    endcase
    return e;
  endfunction

  logic [md5_pkg::PC_W-1:0] pc_q, pc_d;
  logic [md5_pkg::PC_W-1:0] ret_q, ret_d;
  logic [md5_pkg::PC_W-1:0] pc_inc;
  md5_pkg::ctrl_t           cw;

  assign cw     = rom(pc_q);
  assign ctrl_o = cw;
  assign pc_inc = pc_q + 1'b1;

  always_comb begin
    pc_d  = pc_q;
    ret_d = ret_q;
    unique case (cw.cond)
      md5_pkg::COND_NEXT:     pc_d = pc_inc;
      md5_pkg::COND_JUMP:     pc_d = cw.target;
      md5_pkg::COND_DISPATCH: pc_d = in_valid_i ? entry(cmd_i) : pc_q;
      md5_pkg::COND_ABS_CONT: begin
        if (stat_i.wrap) begin
          ret_d = cw.target;
          pc_d  = S_CMP_INI;
        end else begin
          pc_d = cw.target;
        end
      end
      md5_pkg::COND_LEN_CONT: begin
        if (stat_i.wrap) begin
          ret_d = cw.target;
          pc_d  = S_CMP_INI;
        end else begin
          pc_d = pc_q;
        end
      end
      md5_pkg::COND_POS56:    pc_d = stat_i.pos56 ? cw.target : pc_inc;
      md5_pkg::COND_EMIT:     pc_d = (stat_i.out_free && stat_i.emit_last) ? cw.target : pc_q;
      md5_pkg::COND_ROUND:    pc_d = stat_i.round_last ? pc_inc : pc_q;
      md5_pkg::COND_RET:      pc_d = ret_q;
      default:                pc_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q  <= S_IDLE;
      ret_q <= S_IDLE;
    end else begin
      pc_q  <= pc_d;
      ret_q <= ret_d;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/md5_dpath.sv
// Datapath: block buffer, byte count, chaining and working words, round unit, output register.
`default_nettype none

module md5_dpath (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire md5_pkg::ctrl_t ctrl_i,
  input  wire logic           in_acc_i,
  input  wire logic [7:0]     data_byte_i,
  input  wire logic           out_ready_i,
  output md5_pkg::stat_t      stat_o,
  output logic                out_valid_o,
  output logic [31:0]         digest_word_o,
  output logic [1:0]          word_index_o,
  output logic                last_word_o
);

  logic [31:0]               buf_q [16];
  logic [31:0]               chain_q [4];
  logic [31:0]               work_q [4];
  logic [md5_pkg::CNT_W-1:0] count_q;
  logic [63:0]               len_q;
  logic [5:0]                round_q;
  logic [31:0]               kw_q;
  logic [7:0]                byte_q;
  logic [1:0]                widx_q;
  logic                      out_valid_q;
  logic [31:0]               digest_q;
  logic [1:0]                index_q;
  logic                      last_q;

  logic [5:0]  pos;
  logic [7:0]  abs_byte;
  logic [63:0] len_sh;
  logic [5:0]  pf_rnd;
  logic [31:0] rnd_t;
  logic [31:0] rnd_b;
  logic        out_free;

  assign pos      = count_q[5:0];
  assign len_sh   = len_q >> {pos[2:0], 3'b000};
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    unique case (ctrl_i.src)
      md5_pkg::SRC_DATA: abs_byte = byte_q;
      md5_pkg::SRC_PAD:  abs_byte = md5_pkg::PAD_BYTE;
      md5_pkg::SRC_ZERO: abs_byte = 8'h00;
      default:           abs_byte = len_sh[7:0];
    endcase
  end

  assign pf_rnd = ctrl_i.cmp_init ? 6'd0 : round_q + 6'd1;
  assign rnd_t  = work_q[0] + md5_pkg::round_f(round_q[5:4], work_q[1], work_q[2], work_q[3])
                  + kw_q;
  assign rnd_b  = work_q[1] + md5_pkg::rotl(rnd_t, md5_pkg::ROT_TAB[{round_q[5:4], round_q[1:0]}]);

  assign stat_o.wrap       = ctrl_i.abs_en && (pos == md5_pkg::LAST_POS);
  assign stat_o.pos56      = pos == md5_pkg::LEN_POS;
  assign stat_o.round_last = round_q == md5_pkg::LAST_RND;
  assign stat_o.emit_last  = widx_q == 2'd3;
  assign stat_o.out_free   = out_free;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.abs_en) begin
      buf_q[pos[5:2]][{pos[1:0], 3'b000} +: 8] <= abs_byte;
    end
    if (ctrl_i.cmp_init || ctrl_i.cmp_round) begin
      kw_q <= buf_q[md5_pkg::msg_idx(pf_rnd)] + md5_pkg::K_TAB[pf_rnd];
    end
    if (ctrl_i.cmp_init) begin
      work_q <= chain_q;
    end else if (ctrl_i.cmp_round) begin
      work_q[0] <= work_q[3];
      work_q[1] <= rnd_b;
      work_q[2] <= work_q[1];
      work_q[3] <= work_q[2];
    end
    if (ctrl_i.len_cap) begin
      len_q <= {count_q, 3'b000};
    end
    if (in_acc_i) begin
      byte_q <= data_byte_i;
    end
    if (ctrl_i.emit && out_free) begin
      digest_q <= chain_q[widx_q];
      index_q  <= widx_q;
      last_q   <= widx_q == 2'd3;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q     <= md5_pkg::IV_TAB;
      count_q     <= '0;
      round_q     <= '0;
      widx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.load_iv) begin
        chain_q <= md5_pkg::IV_TAB;
        count_q <= '0;
      end else begin
        if (ctrl_i.abs_en) begin
          count_q <= count_q + 1'b1;
        end
        if (ctrl_i.cmp_add) begin
          for (int k = 0; k < 4; k++) begin
            chain_q[k] <= chain_q[k] + work_q[k];
          end
        end
      end
      if (ctrl_i.cmp_init) begin
        round_q <= '0;
      end else if (ctrl_i.cmp_round) begin
        round_q <= round_q + 6'd1;
      end
      if (ctrl_i.emit && out_free) begin
        out_valid_q <= 1'b1;
        widx_q      <= widx_q + 2'd1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign digest_word_o = digest_q;
  assign word_index_o  = index_q;
  assign last_word_o   = last_q;

endmodule

`default_nettype wire

>>> dv/testbench.sv
// Self-checking testbench for the MD5 stream hasher, with a byte-level digest predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned HOLD_AT     = 100;
  localparam int unsigned HOLD_LEN    = 400;
  localparam int unsigned CALM_FROM   = 1500;
  localparam int unsigned CALM_TO     = 3500;
  localparam int unsigned DRAIN       = 300;
  localparam int unsigned ITEM_TARGET = 300;

  localparam logic [31:0] INIT_CHAIN [4] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
  };
  localparam int ROT_AMT [16] = '{
    7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
  };

  typedef struct {
    logic [1:0] cmd;
    logic [7:0] data;
  } hash_req_t;

  typedef struct {
    logic [31:0] word;
    logic [1:0]  idx;
    logic        last;
  } digest_beat_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic [1:0]  cmd_i       = md5_pkg::CMD_ABSORB;
  logic [7:0]  data_byte_i = 8'h00;
  logic        out_ready_i = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [31:0] digest_word_o;
  logic [1:0]  word_index_o;
  logic        last_word_o;

  hash_req_t    req_q[$];
  digest_beat_t digest_q[$];

  logic [31:0] chain_w [4];
  logic [31:0] blk_w [16];
  logic [60:0] msg_len;
  logic [31:0] round_k [64];

  int unsigned n_total  = 0;
  int unsigned n_taken  = 0;
  int unsigned err_cnt  = 0;
  int unsigned cyc      = 0;
  int unsigned hold_left = 0;
  hash_req_t   cur_req;
  digest_beat_t want;

  md5_stream_hasher_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cmd_i         (cmd_i),
    .data_byte_i   (data_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .digest_word_o (digest_word_o),
    .word_index_o  (word_index_o),
    .last_word_o   (last_word_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic void md5_compress();
    logic [31:0] a, b, c, d, f, t, nb;
    int g, s;
    a = chain_w[0];
    b = chain_w[1];
    c = chain_w[2];
    d = chain_w[3];
    for (int r = 0; r < 64; r++) begin
      case (r / 16)
        0: begin
          f = (b & c) | (~b & d);
          g = r;
        end
        1: begin
          f = (d & b) | (~d & c);
          g = (5 * r + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * r + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * r) % 16;
        end
      endcase
      s  = ROT_AMT[(r / 16) * 4 + (r % 4)];
      t  = a + f + blk_w[g] + round_k[r];
      nb = b + ((t << s) | (t >> (32 - s)));
      a  = d;
      d  = c;
      c  = b;
      b  = nb;
    end
    chain_w[0] = chain_w[0] + a;
    chain_w[1] = chain_w[1] + b;
    chain_w[2] = chain_w[2] + c;
    chain_w[3] = chain_w[3] + d;
  endfunction

  function automatic void md5_absorb(input logic [7:0] b);
    logic [5:0] pos;
    pos = msg_len[5:0];
    blk_w[pos[5:2]][8 * pos[1:0] +: 8] = b;
    msg_len = msg_len + 61'd1;
    if (msg_len[5:0] == 6'd0) md5_compress();
  endfunction

  function automatic void md5_emit();
    digest_beat_t beat;
    for (int k = 0; k < 4; k++) begin
      beat.word = chain_w[k];
      beat.idx  = 2'(k);
      beat.last = (k == 3);
      digest_q.push_back(beat);
    end
  endfunction

  function automatic void md5_take(input logic [1:0] cmd, input logic [7:0] b);
    logic [63:0] bits;
    case (cmd)
      md5_pkg::CMD_ABSORB: md5_absorb(b);
      md5_pkg::CMD_RESTART: begin
        for (int k = 0; k < 4; k++) chain_w[k] = INIT_CHAIN[k];
        msg_len = '0;
      end
      md5_pkg::CMD_FINISH: begin
        bits = {msg_len, 3'b000};
        md5_absorb(8'h80);
        while (msg_len[5:0] != 6'd56) md5_absorb(8'h00);
        for (int i = 0; i < 8; i++) md5_absorb(bits[8 * i +: 8]);
        md5_emit();
      end
      default: md5_emit();
    endcase
  endfunction

  function automatic bit idle_now();
    if (cyc >= CALM_FROM && cyc < CALM_TO) return 1'b0;
    return $urandom_range(0, 99) < 34;
  endfunction

  task automatic push_req(input logic [1:0] cmd, input logic [7:0] data);
    hash_req_t r;
    r.cmd  = cmd;
    r.data = data;
    req_q.push_back(r);
    n_total++;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    $display("mismatch %s: got %h want %h (cycle %0d)", what, got, exp_val, cyc);
    err_cnt++;
  endtask

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end else if (cyc == HOLD_AT) begin
        hold_left <= HOLD_LEN;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        md5_take(cmd_i, data_byte_i);
        n_taken++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (req_q.size() != 0 && !idle_now()) begin
          cur_req = req_q.pop_front();
          in_valid_i  <= 1'b1;
          cmd_i       <= cur_req.cmd;
          data_byte_i <= cur_req.data;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (digest_q.size() == 0) begin
          report_mismatch("unexpected transaction", digest_word_o, 32'h0);
        end else begin
          want = digest_q.pop_front();
          if (digest_word_o !== want.word)
            report_mismatch("digest_word", digest_word_o, want.word);
          if (word_index_o !== want.idx)
            report_mismatch("word_index", 32'(word_index_o), 32'(want.idx));
          if (last_word_o !== want.last)
            report_mismatch("last_word", 32'(last_word_o), 32'(want.last));
        end
      end
      out_ready_i <= (hold_left == 0) && !idle_now();
    end
  end

  initial begin
    int unsigned kind, len, sel;
    real v;
    for (int i = 0; i < 64; i++) begin
      v = $sin(i + 1);
      if (v < 0.0) v = -v;
      round_k[i] = 32'(longint'($floor(v * 4294967296.0)));
    end
    for (int k = 0; k < 4; k++) chain_w[k] = INIT_CHAIN[k];
    for (int k = 0; k < 16; k++) blk_w[k] = '0;
    msg_len = '0;

    // directed: empty message, continuation after finish, "abc", reads
    push_req(md5_pkg::CMD_READ, 8'hFF);
    push_req(md5_pkg::CMD_FINISH, 8'hA5);
    push_req(md5_pkg::CMD_READ, 8'h00);
    push_req(md5_pkg::CMD_ABSORB, 8'h00);
    push_req(md5_pkg::CMD_ABSORB, 8'hFF);
    push_req(md5_pkg::CMD_ABSORB, 8'h61);
    push_req(md5_pkg::CMD_FINISH, 8'h00);
    push_req(md5_pkg::CMD_RESTART, 8'hFF);
    push_req(md5_pkg::CMD_ABSORB, 8'h61);
    push_req(md5_pkg::CMD_ABSORB, 8'h62);
    push_req(md5_pkg::CMD_ABSORB, 8'h63);
    push_req(md5_pkg::CMD_FINISH, 8'h5A);
    push_req(md5_pkg::CMD_READ, 8'h3C);
    push_req(md5_pkg::CMD_READ, 8'hC3);
    push_req(md5_pkg::CMD_READ, 8'h81);
    push_req(md5_pkg::CMD_RESTART, 8'h00);
    push_req(md5_pkg::CMD_FINISH, 8'hFF);
    push_req(md5_pkg::CMD_RESTART, 8'h7E);

    while (n_total < ITEM_TARGET) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        repeat ($urandom_range(1, 3)) push_req(2'($urandom_range(0, 3)), 8'($urandom));
      end else if (kind == 1) begin
        push_req(md5_pkg::CMD_READ, 8'($urandom));
      end else begin
        sel = $urandom_range(0, 7);
        case (sel)
          0, 1, 2: len = $urandom_range(0, 12);
          3:       len = $urandom_range(0, 3);
          4:       len = $urandom_range(52, 60);
          5:       len = $urandom_range(61, 66);
          6:       len = $urandom_range(118, 130);
          default: len = $urandom_range(13, 40);
        endcase
        if (len > ITEM_TARGET - n_total) len = ITEM_TARGET - n_total;
        push_req(md5_pkg::CMD_RESTART, 8'($urandom));
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 19) == 0) push_req(md5_pkg::CMD_READ, 8'($urandom));
          push_req(md5_pkg::CMD_ABSORB, 8'($urandom));
        end
        push_req(md5_pkg::CMD_FINISH, 8'($urandom));
      end
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (n_taken != n_total || digest_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/md5_pkg.sv
hw/rtl/md5_seq.sv
hw/rtl/md5_dpath.sv
hw/rtl/md5_stream_hasher_unit.sv
dv/testbench.sv
